// ===== src/best_fit_block_allocator_assert.svh =====
// Assertion macros for the best-fit allocator.
`ifndef BEST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define BFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BFA_ASSERT_AFTER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) rst_n |=> prop) else $error(msg);
`else
`define BFA_ASSERT(lbl, prop, msg)
`define BFA_ASSERT_AFTER(lbl, prop, msg)
`endif

`endif

// ===== src/bfa_pkg.sv =====
`default_nettype none
package bfa_pkg;
  localparam int MAX_FREE   = 32;
  localparam int IDX_W      = 5;
  localparam int CNT_W      = 6;
  localparam int ADDR_W     = 16;
  localparam int SIZE_W     = 17;
  localparam int LIMIT_W    = 17;
  localparam int HDR        = 16;
  localparam int SPLIT_MIN  = 8;
  localparam int STORE_AW   = 13;
  localparam int LIMIT_RST  = 65536;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NOSPACE = 2'd1,
    STAT_FULL    = 2'd2
  } bfa_status_t;

  typedef struct packed {
    logic              is_free;
    logic              bad;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
  } bfa_op_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] size;
  } bfa_ent_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ASCAN, S_ADEC, S_GROW, S_FSIZE, S_FSCAN,
    S_FDEC, S_SHDN, S_SHUP, S_FINS, S_RESP
  } bfa_state_t;
endpackage
`default_nettype wire

// ===== src/bfa_front.sv =====
`default_nettype none
module bfa_front import bfa_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_action,
  input  wire logic [ADDR_W-1:0] in_req_size,
  input  wire logic [ADDR_W-1:0] in_block_addr,
  output logic                   q_valid,
  input  wire logic              q_ready,
  output bfa_op_t                q_op
);
  bfa_op_t    mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  bfa_op_t    op;
  logic       push, pop;

  always_comb begin
    op.is_free = (in_action == ACT_FREE);
    op.size    = ({1'b0, in_req_size} + SIZE_W'(7)) & ~SIZE_W'(7);
    op.addr    = in_block_addr;
    op.bad     = (in_block_addr < ADDR_W'(HDR)) || (in_block_addr[2:0] != 3'd0);
  end

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_op     = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ===== src/bfa_back.sv =====
`default_nettype none
`include "best_fit_block_allocator_assert.svh"
module bfa_back import bfa_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  output logic                    q_ready,
  input  wire bfa_op_t            q_op,
  input  wire logic               cfg_we,
  input  wire logic [LIMIT_W-1:0] cfg_wdata,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [ADDR_W-1:0]       out_result_addr,
  output logic [1:0]              out_status
);
  bfa_state_t state_r, state_nxt;

  bfa_ent_t          ft_mem [MAX_FREE];
  bfa_ent_t          ft_q;
  logic [ADDR_W-1:0] st_mem [1 << STORE_AW];
  logic [ADDR_W-1:0] st_q;

  bfa_op_t            op_r;
  logic [CNT_W-1:0]   cnt_r, idx_r, rem_r, cur_r, pos_r;
  logic [LIMIT_W-1:0] brk_r, lim_r;
  logic               pend_r, found_r, hasnext_r;
  logic [IDX_W-1:0]   best_r;
  logic [ADDR_W-1:0]  bdiff_r, s_r, res_addr_r;
  bfa_ent_t           bent_r, prev_r, next_r;
  bfa_status_t        res_st_r;
  logic               out_valid_r;
  logic [ADDR_W-1:0]  out_addr_r;
  bfa_status_t        out_st_r;

  logic               ft_we, st_we;
  logic [IDX_W-1:0]   ft_wa;
  bfa_ent_t           ft_wd;
  logic [STORE_AW-1:0] st_wa, st_ra;
  logic [ADDR_W-1:0]  st_wd;

  logic               issue, fits, exact, better, ascan_done, fscan_done, le, split;
  logic               mprev, mnext, gfail, full, resp_go, pop;
  logic [ADDR_W-1:0]  d, h;
  logic [LIMIT_W-1:0] limeff;
  logic [17:0]        gsum;
  logic [CNT_W-1:0]   cur_dn, cur_up, pos_dn;

  assign h      = op_r.addr - ADDR_W'(HDR);
  assign issue  = (state_r == S_SHUP) ? (rem_r != '0) : (idx_r < cnt_r);
  assign fits   = {1'b0, ft_q.size} >= op_r.size;
  assign d      = ft_q.size - op_r.size[ADDR_W-1:0];
  assign exact  = fits && (d == '0);
  assign better = fits && (exact || !found_r || (d < bdiff_r));
  assign ascan_done = (pend_r && exact) || (!pend_r && !issue);
  assign le     = ft_q.start <= h;
  assign fscan_done = (pend_r && !le) || (!pend_r && !issue);
  assign split  = {2'b0, bent_r.size} >= ({1'b0, op_r.size} + 18'(HDR + SPLIT_MIN));
  assign limeff = (lim_r > LIMIT_W'(LIMIT_RST)) ? LIMIT_W'(LIMIT_RST) : lim_r;
  assign gsum   = {1'b0, brk_r} + {1'b0, op_r.size} + 18'(HDR);
  assign gfail  = (gsum > {1'b0, limeff}) ||
                  (({1'b0, brk_r} + 18'(HDR)) >= 18'(LIMIT_RST));
  assign mprev  = (pos_r != '0) &&
                  (({2'b0, prev_r.start} + 18'(HDR) + {2'b0, prev_r.size}) == {2'b0, h});
  assign mnext  = hasnext_r &&
                  (({2'b0, h} + 18'(HDR) + {2'b0, s_r}) == {2'b0, next_r.start});
  assign full   = cnt_r >= CNT_W'(MAX_FREE);
  assign cur_dn = cur_r - CNT_W'(1);
  assign cur_up = cur_r + CNT_W'(1);
  assign pos_dn = pos_r - CNT_W'(1);
  assign resp_go = !out_valid_r || out_ready;
  assign q_ready = (state_r == S_IDLE);
  assign pop     = q_valid && q_ready;
  assign st_ra   = q_op.addr[ADDR_W-1:3];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (pop) begin
          if (!q_op.is_free) state_nxt = (cnt_r == '0) ? S_GROW : S_ASCAN;
          else               state_nxt = q_op.bad ? S_RESP : S_FSIZE;
        end
      end
      S_ASCAN: if (ascan_done) state_nxt = S_ADEC;
      S_ADEC: begin
        if (!found_r)   state_nxt = S_GROW;
        else if (split) state_nxt = S_RESP;
        else            state_nxt = S_SHDN;
      end
      S_GROW:  state_nxt = S_RESP;
      S_FSIZE: state_nxt = S_FSCAN;
      S_FSCAN: if (fscan_done) state_nxt = S_FDEC;
      S_FDEC: begin
        priority if (mprev && mnext) state_nxt = S_SHDN;
        else if (mprev || mnext)     state_nxt = S_RESP;
        else if (full)               state_nxt = S_RESP;
        else                         state_nxt = S_SHUP;
      end
      S_SHDN:  if (!pend_r && !issue) state_nxt = S_RESP;
      S_SHUP:  if (!pend_r && !issue) state_nxt = S_FINS;
      S_FINS:  state_nxt = S_RESP;
      S_RESP:  if (resp_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ft_we = 1'b0;
    ft_wa = cur_r[IDX_W-1:0];
    ft_wd = ft_q;
    st_we = 1'b0;
    st_wa = bent_r.start[ADDR_W-1:3] + STORE_AW'(HDR >> 3);
    st_wd = op_r.size[ADDR_W-1:0];
    unique case (state_r)
      S_ADEC: begin
        if (found_r) begin
          st_we = 1'b1;
          if (split) begin
            ft_we = 1'b1;
            ft_wa = best_r;
            ft_wd.start = bent_r.start + ADDR_W'(HDR) + op_r.size[ADDR_W-1:0];
            ft_wd.size  = bent_r.size - op_r.size[ADDR_W-1:0] - ADDR_W'(HDR);
          end else begin
            st_wd = bent_r.size;
          end
        end
      end
      S_GROW: begin
        st_we = !gfail;
        st_wa = brk_r[ADDR_W-1:3] + STORE_AW'(HDR >> 3);
      end
      S_FDEC: begin
        if (mprev) begin
          ft_we = 1'b1;
          ft_wa = pos_dn[IDX_W-1:0];
          ft_wd.start = prev_r.start;
          ft_wd.size  = mnext ?
            prev_r.size + ADDR_W'(HDR) + s_r + ADDR_W'(HDR) + next_r.size :
            prev_r.size + ADDR_W'(HDR) + s_r;
        end else if (mnext) begin
          ft_we = 1'b1;
          ft_wa = pos_r[IDX_W-1:0];
          ft_wd.start = h;
          ft_wd.size  = s_r + ADDR_W'(HDR) + next_r.size;
        end
      end
      S_SHDN: begin
        ft_we = pend_r;
        ft_wa = cur_dn[IDX_W-1:0];
      end
      S_SHUP: begin
        ft_we = pend_r;
        ft_wa = cur_up[IDX_W-1:0];
      end
      S_FINS: begin
        ft_we = 1'b1;
        ft_wa = pos_r[IDX_W-1:0];
        ft_wd.start = h;
        ft_wd.size  = s_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    ft_q <= ft_mem[idx_r[IDX_W-1:0]];
    if (ft_we) ft_mem[ft_wa] <= ft_wd;
  end

  always_ff @(posedge clk) begin
    st_q <= st_mem[st_ra];
    if (st_we) st_mem[st_wa] <= st_wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      brk_r       <= '0;
      lim_r       <= LIMIT_W'(LIMIT_RST);
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) lim_r <= cfg_wdata;
      if (state_r == S_RESP && resp_go) out_valid_r <= 1'b1;
      else if (out_ready)               out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          op_r       <= q_op;
          idx_r      <= '0;
          pend_r     <= 1'b0;
          found_r    <= 1'b0;
          res_addr_r <= '0;
          res_st_r   <= STAT_OK;
        end
        S_ASCAN: begin
          if (issue) idx_r <= idx_r + CNT_W'(1);
          pend_r <= issue;
          cur_r  <= idx_r;
          if (pend_r && better) begin
            best_r  <= cur_r[IDX_W-1:0];
            bdiff_r <= d;
            bent_r  <= ft_q;
            found_r <= 1'b1;
          end
        end
        S_ADEC: begin
          pend_r <= 1'b0;
          idx_r  <= {1'b0, best_r} + CNT_W'(1);
          if (found_r) res_addr_r <= bent_r.start + ADDR_W'(HDR);
        end
        S_GROW: begin
          if (gfail) begin
            res_st_r <= STAT_NOSPACE;
          end else begin
            res_addr_r <= brk_r[ADDR_W-1:0] + ADDR_W'(HDR);
            brk_r      <= gsum[LIMIT_W-1:0];
          end
        end
        S_FSIZE: begin
          s_r       <= st_q;
          pos_r     <= '0;
          hasnext_r <= 1'b0;
        end
        S_FSCAN: begin
          if (issue) idx_r <= idx_r + CNT_W'(1);
          pend_r <= issue;
          cur_r  <= idx_r;
          if (pend_r) begin
            if (le) begin
              prev_r <= ft_q;
              pos_r  <= cur_up;
            end else begin
              next_r    <= ft_q;
              hasnext_r <= 1'b1;
            end
          end
        end
        S_FDEC: begin
          pend_r <= 1'b0;
          if (!mprev && !mnext) begin
            if (full) res_st_r <= STAT_FULL;
            idx_r <= cnt_r - CNT_W'(1);
            rem_r <= cnt_r - pos_r;
          end else begin
            idx_r <= pos_r + CNT_W'(1);
          end
        end
        S_SHDN: begin
          if (issue) idx_r <= idx_r + CNT_W'(1);
          pend_r <= issue;
          cur_r  <= idx_r;
          if (!pend_r && !issue) cnt_r <= cnt_r - CNT_W'(1);
        end
        S_SHUP: begin
          if (issue) begin
            idx_r <= idx_r - CNT_W'(1);
            rem_r <= rem_r - CNT_W'(1);
          end
          pend_r <= issue;
          cur_r  <= idx_r;
        end
        S_FINS: cnt_r <= cnt_r + CNT_W'(1);
        S_RESP: begin
          if (resp_go) begin
            out_addr_r  <= res_addr_r;
            out_st_r    <= res_st_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_addr = out_addr_r;
  assign out_status      = out_st_r;

  `BFA_ASSERT(a_cnt_max, cnt_r <= CNT_W'(MAX_FREE), "free table count overflow")
  `BFA_ASSERT(a_brk_max, brk_r <= LIMIT_W'(LIMIT_RST), "break pointer past address space")
  `BFA_ASSERT_AFTER(a_brk_mono, brk_r >= $past(brk_r), "break pointer moved back")
  `BFA_ASSERT_AFTER(a_cnt_step, (cnt_r == $past(cnt_r)) || (cnt_r == $past(cnt_r) + CNT_W'(1)) || (cnt_r == $past(cnt_r) - CNT_W'(1)), "free count jumped")
endmodule
`default_nettype wire

// ===== src/best_fit_block_allocator.sv =====
// Back-end steps from input beat to result beat:
//   allocate scans the table, then shifts entries down on a remove; an empty table goes to the break pointer;
//   free scans up to the insert point, then merges or shifts the rest up and inserts.
// Throughput: one request at a time in the back end; a 2-deep queue keeps taking beats.
// The free-table RAM reads one entry per cycle in scan and shift, which sets the rate.
// Reset (rst_n low, synchronous): table empty, break pointer 0, heap_limit 65536.
`default_nettype none
module best_fit_block_allocator import bfa_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_action,
  input  wire logic [ADDR_W-1:0]  in_req_size,
  input  wire logic [ADDR_W-1:0]  in_block_addr,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [ADDR_W-1:0]       out_result_addr,
  output logic [1:0]              out_status,
  input  wire logic               cfg_we,
  input  wire logic [LIMIT_W-1:0] cfg_wdata
);
  logic    q_valid, q_ready;
  bfa_op_t q_op;

  bfa_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_action, .in_req_size, .in_block_addr,
    .q_valid, .q_ready, .q_op
  );

  bfa_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_op, .cfg_we, .cfg_wdata,
    .out_valid, .out_ready, .out_result_addr, .out_status
  );
endmodule
`default_nettype wire

// ===== test/bfa_checker.sv =====
module bfa_checker import bfa_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic               in_action,
  input  wire logic [ADDR_W-1:0]  in_req_size,
  input  wire logic [ADDR_W-1:0]  in_block_addr,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic [ADDR_W-1:0]  out_result_addr,
  input  wire logic [1:0]         out_status,
  input  wire logic               cfg_we,
  input  wire logic [LIMIT_W-1:0] cfg_wdata,
  output int                      fails,
  output int                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    bfa_status_t       status;
  } reply_t;

  int     hole_start[MAX_FREE];
  int     hole_size[MAX_FREE];
  int     hole_count;
  int     brk;
  int     heap_limit;
  int     block_sizes[1 << STORE_AW];
  reply_t owed_replies[$];

  task automatic drop_hole(input int i);
    for (int j = i; j + 1 < hole_count; j++) begin
      hole_start[j] = hole_start[j + 1];
      hole_size[j]  = hole_size[j + 1];
    end
    if (hole_count > 0) hole_count--;
  endtask

  task automatic grant_block(input int req, output reply_t r);
    int sz, best, bdiff, d, st, fs, bs, pay, lim;
    bit found;
    sz = ((req + 7) / 8) * 8;
    found = 0;
    best = 0;
    bdiff = 0;
    for (int i = 0; i < hole_count; i++) begin
      if (hole_size[i] >= sz) begin
        d = hole_size[i] - sz;
        if (d == 0) begin
          best = i;
          found = 1;
          break;
        end
        if (!found || d < bdiff) begin
          best = i;
          bdiff = d;
          found = 1;
        end
      end
    end
    r.addr = '0;
    r.status = STAT_OK;
    if (found) begin
      st = hole_start[best];
      fs = hole_size[best];
      if (fs >= sz + HDR + SPLIT_MIN) begin
        hole_start[best] = (st + HDR + sz) & 'hFFFF;
        hole_size[best]  = (fs - sz - HDR) & 'hFFFF;
        bs = sz;
      end else begin
        drop_hole(best);
        bs = fs;
      end
      pay = (st + HDR) & 'hFFFF;
      block_sizes[(pay >> 3) & ((1 << STORE_AW) - 1)] = bs & 'hFFFF;
      r.addr = pay[ADDR_W-1:0];
    end else begin
      lim = heap_limit < 65536 ? heap_limit : 65536;
      if (brk + sz + HDR > lim || brk + HDR >= 65536) begin
        r.status = STAT_NOSPACE;
      end else begin
        pay = brk + HDR;
        brk = brk + sz + HDR;
        block_sizes[(pay >> 3) & ((1 << STORE_AW) - 1)] = sz & 'hFFFF;
        r.addr = pay[ADDR_W-1:0];
      end
    end
  endtask

  task automatic return_block(input int addr, output reply_t r);
    int h, s, pos;
    bit mprev, mnext;
    r.addr = '0;
    r.status = STAT_OK;
    if (addr < HDR || (addr % 8) != 0) return;
    h = addr - HDR;
    s = block_sizes[(addr >> 3) & ((1 << STORE_AW) - 1)];
    pos = 0;
    while (pos < hole_count && hole_start[pos] <= h) pos++;
    mprev = 0;
    mnext = 0;
    if (pos > 0) mprev = (hole_start[pos-1] + HDR + hole_size[pos-1] == h);
    if (pos < hole_count) mnext = (h + HDR + s == hole_start[pos]);
    if (mprev && mnext) begin
      hole_size[pos-1] = (hole_size[pos-1] + HDR + s + HDR + hole_size[pos]) & 'hFFFF;
      drop_hole(pos);
    end else if (mprev) begin
      hole_size[pos-1] = (hole_size[pos-1] + HDR + s) & 'hFFFF;
    end else if (mnext) begin
      hole_size[pos]  = (s + HDR + hole_size[pos]) & 'hFFFF;
      hole_start[pos] = h & 'hFFFF;
    end else if (hole_count >= MAX_FREE) begin
      r.status = STAT_FULL;
    end else begin
      for (int j = hole_count; j > pos; j--) begin
        hole_start[j] = hole_start[j-1];
        hole_size[j]  = hole_size[j-1];
      end
      hole_start[pos] = h & 'hFFFF;
      hole_size[pos]  = s & 'hFFFF;
      hole_count++;
    end
  endtask

  initial fails = 0;
  assign pending = owed_replies.size();

  always @(posedge clk) begin
    reply_t r, want;
    if (!rst_n) begin
      hole_count = 0;
      brk = 0;
      heap_limit = LIMIT_RST;
      owed_replies.delete();
    end else begin
      if (cfg_we) heap_limit = cfg_wdata;
      if (out_valid && out_ready) begin
        if (owed_replies.size() == 0) begin
          fails++;
          $display("%0t: unexpected beat, expected none actual addr %h status %0d",
                   $time, out_result_addr, out_status);
        end else begin
          want = owed_replies.pop_front();
          if (out_result_addr !== want.addr) begin
            fails++;
            $display("%0t: result_addr mismatch, expected %h actual %h",
                     $time, want.addr, out_result_addr);
          end
          if (out_status !== want.status) begin
            fails++;
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, want.status, out_status);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_action == ACT_ALLOC) grant_block(int'(in_req_size), r);
        else return_block(int'(in_block_addr), r);
        owed_replies.push_back(r);
      end
    end
  end
endmodule

// ===== test/testbench.sv =====
module testbench import bfa_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_ready;
  logic               in_action = ACT_ALLOC;
  logic [ADDR_W-1:0]  in_req_size = '0;
  logic [ADDR_W-1:0]  in_block_addr = '0;
  logic               out_valid;
  logic               out_ready = 0;
  logic [ADDR_W-1:0]  out_result_addr;
  logic [1:0]         out_status;
  logic               cfg_we = 0;
  logic [LIMIT_W-1:0] cfg_wdata = '0;
  int                 fails;
  int                 pending;
  int                 tx_idle = 0;
  int                 rx_idle = 0;
  bit                 hold_req = 0;
  int                 cycles = 0;
  int                 live_blocks[$];
  int                 granted_ever[$];

  best_fit_block_allocator i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_req_size(in_req_size), .in_block_addr(in_block_addr),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result_addr(out_result_addr), .out_status(out_status),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  bfa_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_req_size(in_req_size), .in_block_addr(in_block_addr),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result_addr(out_result_addr), .out_status(out_status),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fails(fails), .pending(pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // track granted blocks so frees can name real ones
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready && out_status == STAT_OK && out_result_addr != 0) begin
      live_blocks.push_back(int'(out_result_addr));
      granted_ever.push_back(int'(out_result_addr));
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  task automatic send(input logic act, input int sz, input int ad);
    int gap;
    in_valid <= 1;
    in_action <= act;
    in_req_size <= sz[ADDR_W-1:0];
    in_block_addr <= ad[ADDR_W-1:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (tx_idle > 0 && $urandom_range(99) < tx_idle) begin
      in_valid <= 0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input int v);
    cfg_we <= 1;
    cfg_wdata <= v[LIMIT_W-1:0];
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  function automatic int bad_addr();
    int a;
    a = $urandom_range(99) < 30 ? $urandom_range(15) & ~7 : $urandom & 'hFFFF;
    if (a >= HDR) a = a | ($urandom_range(1, 7));
    return a;
  endfunction

  task automatic random_item();
    int r, idx, a;
    r = $urandom_range(99);
    if (r < 55) begin
      r = $urandom_range(99);
      if (r < 4) send(ACT_ALLOC, $urandom & 'hFFFF, $urandom);
      else if (r < 25) send(ACT_ALLOC, 8 * $urandom_range(0, 12), $urandom);
      else send(ACT_ALLOC, $urandom_range(0, 400), $urandom);
    end else begin
      r = $urandom_range(99);
      if (r < 82 && live_blocks.size() > 0) begin
        idx = $urandom_range(live_blocks.size() - 1);
        a = live_blocks[idx];
        live_blocks.delete(idx);
      end else if (r < 88 && granted_ever.size() > 0) begin
        a = granted_ever[$urandom_range(granted_ever.size() - 1)];
      end else begin
        a = bad_addr();
      end
      send(ACT_FREE, $urandom & 'hFFFF, a);
    end
  endtask

  initial begin
    int f, g, h, n;
    int limits[6];
    limits = '{65536, 4000, 131071, 0, 20000, 65536};
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    write_limit(LIMIT_RST);

    send(ACT_ALLOC, 0, 0);
    send(ACT_ALLOC, 1, 'hFFFF);
    send(ACT_ALLOC, 7, 0);
    send(ACT_ALLOC, 8, 0);
    send(ACT_ALLOC, 100, 0);
    send(ACT_ALLOC, 'hFFFF, 0);
    send(ACT_ALLOC, 24, 0);
    send(ACT_ALLOC, 24, 0);
    send(ACT_ALLOC, 24, 0);
    drain();
    f = live_blocks[5];
    g = live_blocks[6];
    h = live_blocks[7];
    send(ACT_FREE, 0, 0);
    send(ACT_FREE, 0, 8);
    send(ACT_FREE, 0, 17);
    send(ACT_FREE, 'hFFFF, 'hFFFF);
    send(ACT_FREE, 0, f);
    send(ACT_FREE, 0, h);
    send(ACT_FREE, 0, g);
    send(ACT_ALLOC, 24, 0);
    send(ACT_ALLOC, 64, 0);
    drain();
    write_limit(0);
    send(ACT_ALLOC, 8, 0);
    send(ACT_ALLOC, 0, 0);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_limit(limits[p]);
      tx_idle = p < 2 ? 23 : (p < 4 ? 56 : 0);
      rx_idle = p < 2 ? 56 : (p < 4 ? 23 : 0);
      if (p == 1) begin
        // carve a run of small blocks, then punch holes to fill the table
        write_limit(65536);
        repeat (70) send(ACT_ALLOC, 8, 0);
        drain();
        n = live_blocks.size();
        for (int k = n - 70; k < n; k += 2) send(ACT_FREE, 0, live_blocks[k]);
        drain();
        write_limit(limits[p]);
      end
      if (p == 4) hold_req = 1;
      repeat (p == 1 ? 200 : 260) random_item();
      drain();
    end
    write_limit(131071);

    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fails == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
